### rtl/core/x86_lazy_flag_evaluator_defines.svh
// ----------------------------------------------------------------------------
// x86 lazy flag evaluator assertion macros
// Concurrent check macros used by the flag evaluator top level.
// ----------------------------------------------------------------------------
`ifndef X86_LAZY_FLAG_EVALUATOR_DEFINES_SVH
`define X86_LAZY_FLAG_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// implication checked in the same cycle
`define LFE_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("x86_lazy_flag_evaluator: same-cycle check failed");

// implication checked in the next cycle
`define LFE_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("x86_lazy_flag_evaluator: next-cycle check failed");

`else

`define LFE_ASSERT_NOW(lbl, clk, rst_n, pre, post)
`define LFE_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

### rtl/core/lfe_pkg.sv
// ----------------------------------------------------------------------------
// lfe_pkg
// Types, kind decoding and size helpers for the lazy flag evaluator.
// ----------------------------------------------------------------------------
package lfe_pkg;

	// operation group decoded from the recorded kind
	typedef enum logic [3:0] {
		GRP_ADD,
		GRP_ADC,
		GRP_SUB,
		GRP_SBB,
		GRP_LOGIC,
		GRP_SHL,
		GRP_SHR,
		GRP_MUL,
		GRP_STORED,
		GRP_INC,
		GRP_DEC,
		GRP_BAD
	} kind_grp_t;

	// operand size
	typedef enum logic [1:0] {
		SZ_BYTE,
		SZ_WORD,
		SZ_DWORD
	} op_size_t;

	// jump condition selector, condition bits 3..1
	typedef enum logic [2:0] {
		CC_O,
		CC_B,
		CC_Z,
		CC_BE,
		CC_S,
		CC_P,
		CC_L,
		CC_LE
	} cond_sel_t;

	localparam int unsigned KindW = 5;
	localparam int unsigned DataW = 32;
	localparam int unsigned CondW = 4;
	localparam int unsigned FlagW = 12;

	// eflags bit positions
	localparam int unsigned FlagCf = 0;
	localparam int unsigned FlagPf = 2;
	localparam int unsigned FlagAf = 4;
	localparam int unsigned FlagZf = 6;
	localparam int unsigned FlagSf = 7;
	localparam int unsigned FlagOf = 11;

	// first kind of the increment/decrement range
	localparam logic [KindW-1:0] KindIncFirst = 5'd25;
	localparam logic [KindW-1:0] KindStored = 5'd24;
	// kind with no meaning at all
	localparam logic [KindW-1:0] KindUnsup = 5'd31;

	// status flags plus subtract compare results, one stage to the next
	typedef struct packed {
		logic cf;
		logic pf;
		logic af;
		logic zf;
		logic sf;
		logic of;
		logic be_sub;
		logic lt_sub;
		logic le_sub;
	} flag_set_t;

	function automatic kind_grp_t kind_group(input logic [KindW-1:0] k);
		kind_grp_t g;
		unique case (k)
			5'd0, 5'd1, 5'd2: g = GRP_ADD;
			5'd3, 5'd4, 5'd5: g = GRP_ADC;
			5'd6, 5'd7, 5'd8: g = GRP_SUB;
			5'd9, 5'd10, 5'd11: g = GRP_SBB;
			5'd12, 5'd13, 5'd14: g = GRP_LOGIC;
			5'd15, 5'd16, 5'd17: g = GRP_SHL;
			5'd18, 5'd19, 5'd20: g = GRP_SHR;
			5'd21, 5'd22, 5'd23: g = GRP_MUL;
			5'd24: g = GRP_STORED;
			5'd25, 5'd26, 5'd27: g = GRP_INC;
			5'd28, 5'd29, 5'd30: g = GRP_DEC;
			default: g = GRP_BAD;
		endcase
		return g;
	endfunction

	function automatic op_size_t kind_size(input logic [KindW-1:0] k);
		op_size_t z;
		unique case (k)
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd18, 5'd21, 5'd25, 5'd28:
				z = SZ_BYTE;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd19, 5'd22, 5'd26, 5'd29:
				z = SZ_WORD;
			default: z = SZ_DWORD;
		endcase
		return z;
	endfunction

	function automatic logic [DataW-1:0] size_mask(input op_size_t z);
		logic [DataW-1:0] m;
		unique case (z)
			SZ_BYTE: m = 32'h0000_00ff;
			SZ_WORD: m = 32'h0000_ffff;
			default: m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// one-hot mask of the sign bit for a size
	function automatic logic [DataW-1:0] sign_mask(input op_size_t z);
		logic [DataW-1:0] m;
		unique case (z)
			SZ_BYTE: m = 32'h0000_0080;
			SZ_WORD: m = 32'h0000_8000;
			default: m = 32'h8000_0000;
		endcase
		return m;
	endfunction

endpackage

### rtl/core/lfe_flag_calc.sv
// ----------------------------------------------------------------------------
// lfe_flag_calc
// Rebuilds CF, PF, AF, ZF, SF, OF and the subtract compares from the
// recovered operand and carry term of the previous stage.
// ----------------------------------------------------------------------------
module lfe_flag_calc import lfe_pkg::*; (
	input  kind_grp_t        grp,
	input  kind_grp_t        cgrp,
	input  op_size_t         sz,
	input  op_size_t         csz,
	input  logic [DataW-1:0] src,
	input  logic [DataW-1:0] res,
	input  logic [DataW-1:0] y,
	input  logic [DataW-1:0] cx,
	output flag_set_t        flags
);

	logic [DataW-1:0] m_k;
	logic [DataW-1:0] b_k;
	logic [DataW-1:0] m_c;
	logic [DataW-1:0] ca;
	logic [DataW-1:0] cb;
	logic [DataW-1:0] sx;
	logic [DataW-1:0] sz_y;
	logic             src_nz;

	// size masks for the operation and for the carry source
	always_comb begin
		m_k    = size_mask(sz);
		b_k    = sign_mask(sz);
		m_c    = size_mask(csz);
		ca     = cx & m_c;
		cb     = src & m_c;
		sx     = (src ^ b_k) & m_k;
		sz_y   = (y ^ b_k) & m_k;
		src_nz = src != '0;
	end

	always_comb begin
		// carry, from the kind that last set it
		unique case (cgrp)
			GRP_ADD, GRP_SUB: flags.cf = ca < cb;
			GRP_ADC, GRP_SBB: flags.cf = ca <= cb;
			GRP_SHL:          flags.cf = |(src & sign_mask(csz));
			GRP_SHR:          flags.cf = src[0];
			GRP_MUL:          flags.cf = src_nz;
			GRP_STORED:       flags.cf = src[0];
			default:          flags.cf = 1'b0;
		endcase

		// overflow and adjust
		unique case (grp)
			GRP_ADD, GRP_ADC: flags.of = |(~(y ^ src) & (y ^ res) & b_k);
			GRP_SUB, GRP_SBB: flags.of = |((y ^ src) & (y ^ res) & b_k);
			GRP_SHL, GRP_SHR: flags.of = |((src ^ res) & b_k);
			GRP_MUL:          flags.of = src_nz;
			GRP_STORED:       flags.of = src[FlagOf];
			GRP_INC:          flags.of = (res & m_k) == b_k;
			GRP_DEC:          flags.of = (res & m_k) == (m_k >> 1);
			default:          flags.of = 1'b0;
		endcase
		unique case (grp)
			GRP_ADD, GRP_ADC, GRP_SUB, GRP_SBB: flags.af = res[4] ^ y[4] ^ src[4];
			GRP_STORED: flags.af = src[FlagAf];
			GRP_INC:    flags.af = res[3:0] == 4'h0;
			GRP_DEC:    flags.af = res[3:0] == 4'hf;
			default:    flags.af = 1'b0;
		endcase

		// zero, sign, parity
		flags.zf = res == '0;
		flags.sf = (grp == GRP_STORED) ? src[FlagSf] : res[DataW-1];
		flags.pf = (grp == GRP_STORED) ? src[FlagPf] : ~(^res[7:0]);

		// compares of the original subtract operands, y being the minuend
		flags.be_sub = (y & m_k) <= (src & m_k);
		flags.lt_sub = sz_y < sx;
		flags.le_sub = sz_y <= sx;
	end

endmodule

### rtl/core/x86_lazy_flag_evaluator.sv
// ----------------------------------------------------------------------------
// x86_lazy_flag_evaluator
// Throughput: one beat per cycle; a stage holds only when every stage after
// it is full and the output register holds a beat that is not taken.
// Reset: arst_n clears the stage valid bits; payload registers are not reset.
// Stages: decode, operand recovery add, flag compares, condition select.
// ----------------------------------------------------------------------------
`include "x86_lazy_flag_evaluator_defines.svh"

module x86_lazy_flag_evaluator import lfe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op_kind[4:0], source_value[36:5], result_value[68:37], prior_kind[73:69],
	// prior_result[105:74], condition[109:106], zero fill[111:110]
	input  logic [111:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// flag_word[11:0], condition_true[12], bad_kind[13], zero fill[15:14]
	output logic [15:0]  m_tdata
);

	// input field split
	logic [KindW-1:0] in_kind;
	logic [DataW-1:0] in_src;
	logic [DataW-1:0] in_res;
	logic [KindW-1:0] in_pkind;
	logic [DataW-1:0] in_pres;
	logic [CondW-1:0] in_cond;
	logic             in_incdec;
	logic [KindW-1:0] in_ckind;

	assign in_kind  = s_tdata[4:0];
	assign in_src   = s_tdata[36:5];
	assign in_res   = s_tdata[68:37];
	assign in_pkind = s_tdata[73:69];
	assign in_pres  = s_tdata[105:74];
	assign in_cond  = s_tdata[109:106];

	// stage advance chain
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	assign adv4     = !v_s4 || m_tready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// stage 1: decode kinds and pick the carry source
	assign in_incdec = in_kind >= KindIncFirst;
	assign in_ckind  = in_incdec ? in_pkind : in_kind;

	kind_grp_t        grp_s1, cgrp_s1;
	op_size_t         sz_s1, csz_s1;
	logic [DataW-1:0] src_s1, res_s1, cr_s1;
	logic [CondW-1:0] cond_s1;
	logic             bad_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			grp_s1  <= kind_group(in_kind);
			cgrp_s1 <= kind_group(in_ckind);
			sz_s1   <= kind_size(in_kind);
			csz_s1  <= kind_size(in_ckind);
			src_s1  <= in_src;
			res_s1  <= in_res;
			cr_s1   <= in_incdec ? in_pres : in_res;
			cond_s1 <= in_cond;
			bad_s1  <= (in_kind == KindUnsup) || (in_ckind > KindStored);
		end
	end

	// stage 2: recover the other operand and the carry compare term
	logic [DataW-1:0] y_add;
	logic [DataW-1:0] cx_add;
	logic             y_inv, y_cin, cx_pass, cx_cin;

	always_comb begin
		y_inv   = (grp_s1 == GRP_ADD) || (grp_s1 == GRP_ADC);
		y_cin   = (grp_s1 == GRP_ADD) || (grp_s1 == GRP_SBB);
		cx_pass = (cgrp_s1 == GRP_ADD) || (cgrp_s1 == GRP_ADC);
		cx_cin  = cgrp_s1 == GRP_SBB;
		y_add   = res_s1 + (y_inv ? ~src_s1 : src_s1) + {{(DataW-1){1'b0}}, y_cin};
		cx_add  = cx_pass ? cr_s1 : cr_s1 + src_s1 + {{(DataW-1){1'b0}}, cx_cin};
	end

	kind_grp_t        grp_s2, cgrp_s2;
	op_size_t         sz_s2, csz_s2;
	logic [DataW-1:0] src_s2, res_s2, y_s2, cx_s2;
	logic [CondW-1:0] cond_s2;
	logic             bad_s2;

	always_ff @(posedge clk) begin
		if (adv2) begin
			grp_s2  <= grp_s1;
			cgrp_s2 <= cgrp_s1;
			sz_s2   <= sz_s1;
			csz_s2  <= csz_s1;
			src_s2  <= src_s1;
			res_s2  <= res_s1;
			y_s2    <= y_add;
			cx_s2   <= cx_add;
			cond_s2 <= cond_s1;
			bad_s2  <= bad_s1;
		end
	end

	// stage 3: flags and compares
	flag_set_t flags_c;

	lfe_flag_calc u_flag_calc (
		.grp   (grp_s2),
		.cgrp  (cgrp_s2),
		.sz    (sz_s2),
		.csz   (csz_s2),
		.src   (src_s2),
		.res   (res_s2),
		.y     (y_s2),
		.cx    (cx_s2),
		.flags (flags_c)
	);

	flag_set_t        flags_s3;
	kind_grp_t        grp_s3;
	logic [CondW-1:0] cond_s3;
	logic             bad_s3;
	logic             d31_s3;
	logic             st_cf_s3, st_zf_s3, st_sf_s3, st_of_s3;

	always_ff @(posedge clk) begin
		if (adv3) begin
			flags_s3 <= flags_c;
			grp_s3   <= grp_s2;
			cond_s3  <= cond_s2;
			bad_s3   <= bad_s2;
			d31_s3   <= res_s2[DataW-1];
			st_cf_s3 <= src_s2[FlagCf];
			st_zf_s3 <= src_s2[FlagZf];
			st_sf_s3 <= src_s2[FlagSf];
			st_of_s3 <= src_s2[FlagOf];
		end
	end

	// stage 4: jump condition and flag packing
	cond_sel_t        csel;
	logic             le_sel;
	logic             flg;
	logic [FlagW-1:0] fw;

	always_comb begin
		csel   = cond_sel_t'(cond_s3[CondW-1:1]);
		le_sel = csel == CC_LE;
		unique case (csel)
			CC_O: flg = flags_s3.of;
			CC_B: flg = flags_s3.cf;
			CC_Z: flg = flags_s3.zf;
			CC_BE: begin
				priority if (grp_s3 == GRP_SUB) flg = flags_s3.be_sub;
				else if (grp_s3 == GRP_STORED) flg = st_cf_s3 | st_zf_s3;
				else flg = flags_s3.cf | flags_s3.zf;
			end
			CC_S: flg = flags_s3.sf;
			CC_P: flg = flags_s3.pf;
			default: begin
				priority if (grp_s3 == GRP_SUB)
					flg = le_sel ? flags_s3.le_sub : flags_s3.lt_sub;
				else if ((grp_s3 == GRP_LOGIC) || (grp_s3 == GRP_INC) ||
					(grp_s3 == GRP_DEC))
					flg = d31_s3 | (le_sel & flags_s3.zf);
				else if (grp_s3 == GRP_STORED)
					flg = (st_sf_s3 ^ st_of_s3) | (le_sel & st_zf_s3);
				else
					flg = (flags_s3.sf ^ flags_s3.of) | (le_sel & flags_s3.zf);
			end
		endcase
	end

	always_comb begin
		fw         = '0;
		fw[FlagCf] = flags_s3.cf;
		fw[FlagPf] = flags_s3.pf;
		fw[FlagAf] = flags_s3.af;
		fw[FlagZf] = flags_s3.zf;
		fw[FlagSf] = flags_s3.sf;
		fw[FlagOf] = flags_s3.of;
	end

	logic [FlagW-1:0] flag_word_s4;
	logic             cond_true_s4;
	logic             bad_s4;

	always_ff @(posedge clk) begin
		if (adv4) begin
			flag_word_s4 <= bad_s3 ? '0 : fw;
			cond_true_s4 <= bad_s3 ? 1'b0 : (flg ^ cond_s3[0]);
			bad_s4       <= bad_s3;
		end
	end

	assign m_tdata = {2'b00, bad_s4, cond_true_s4, flag_word_s4};

	// checks
	`LFE_ASSERT_NOW(a_bad_clears_result, clk, arst_n,
		m_tvalid && m_tdata[13], m_tdata[12:0] == 13'd0)
	`LFE_ASSERT_NOW(a_unused_flag_bits_zero, clk, arst_n, m_tvalid,
		(m_tdata[1] == 1'b0) && (m_tdata[3] == 1'b0) && (m_tdata[5] == 1'b0) &&
		(m_tdata[10:8] == 3'd0) && (m_tdata[15:14] == 2'd0))
	`LFE_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, s_tvalid && s_tready, v_s1)
	`LFE_ASSERT_NEXT(a_stall_holds_s3, clk, arst_n, v_s3 && !adv4,
		v_s3 && $stable(flags_s3) && $stable(cond_s3))

endmodule

### dv/flag_eval_checker.sv
// ----------------------------------------------------------------------------
// flag_eval_checker
// Watches both stream channels of the lazy flag evaluator. It works out the
// flags, the jump condition and the bad-kind bit for every accepted input beat
// and compares each output beat, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module flag_eval_checker import lfe_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	// op_kind, source_value, result_value, prior_kind, prior_result, condition
	input  logic [111:0] s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	// flag_word, condition_true, bad_kind
	input  logic [15:0]  m_tdata,
	output int           fail_count,
	output int           pending,
	output int           results_seen,
	output int           bad_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	// one output beat as it lands in m_tdata[13:0]
	typedef struct packed {
		logic        bad;
		logic        cond_true;
		logic [11:0] flags;
	} flag_result_t;

	flag_result_t flags_due[$];

	function automatic kind_grp_t group_of(input logic [KindW-1:0] k);
		if (k < KindStored)
			return kind_grp_t'(k / 5'd3);
		if (k == KindStored)
			return GRP_STORED;
		if (int'(k) < int'(KindIncFirst) + 3)
			return GRP_INC;
		if (int'(k) < int'(KindIncFirst) + 6)
			return GRP_DEC;
		return GRP_BAD;
	endfunction

	// sizes repeat byte, word, dword inside each group
	function automatic op_size_t size_of(input logic [KindW-1:0] k);
		int idx;
		idx = (k >= KindIncFirst) ? (int'(k) - int'(KindIncFirst)) % 3 : int'(k) % 3;
		return op_size_t'(idx);
	endfunction

	function automatic logic [DataW-1:0] mask_of(input op_size_t z);
		case (z)
			SZ_BYTE: return 32'h0000_00ff;
			SZ_WORD: return 32'h0000_ffff;
			default: return 32'hffff_ffff;
		endcase
	endfunction

	function automatic int top_bit(input op_size_t z);
		case (z)
			SZ_BYTE: return 7;
			SZ_WORD: return 15;
			default: return 31;
		endcase
	endfunction

	function automatic flag_result_t eval_flags(input logic [109:0] beat);
		logic [KindW-1:0] k, pk, ck;
		logic [DataW-1:0] s, d, pd, cr, m, cm, y, t, sb, x, yv;
		logic [CondW-1:0] cond;
		kind_grp_t g, cg;
		cond_sel_t sel;
		int b;
		logic cf, pf, af, zf, sf, of, hit, le, inc_dec;
		flag_result_t r;
		{cond, pd, pk, d, s, k} = beat;
		r = '0;
		g = group_of(k);
		inc_dec = (g == GRP_INC) || (g == GRP_DEC);
		ck = inc_dec ? pk : k;
		cr = inc_dec ? pd : d;
		cg = inc_dec ? group_of(pk) : g;
		// unsupported kind, or inc/dec after an inc/dec: no flags at all
		if (g == GRP_BAD || cg == GRP_INC || cg == GRP_DEC || cg == GRP_BAD) begin
			r.bad = 1'b1;
			return r;
		end
		m = mask_of(size_of(k));
		b = top_bit(size_of(k));
		cm = mask_of(size_of(ck));

		// carry comes from the prior operation for inc/dec
		case (cg)
			GRP_ADD:   cf = (cr & cm) < (s & cm);
			GRP_ADC:   cf = (cr & cm) <= (s & cm);
			GRP_SUB:   cf = ((cr + s) & cm) < (s & cm);
			GRP_SBB:   cf = ((cr + s + 32'd1) & cm) <= (s & cm);
			GRP_LOGIC: cf = 1'b0;
			GRP_SHL:   cf = s[top_bit(size_of(ck))];
			GRP_SHR:   cf = s[0];
			GRP_MUL:   cf = s != '0;
			default:   cf = s[FlagCf];
		endcase

		// overflow and adjust; add kinds recover the other operand by subtracting
		of = 1'b0;
		af = 1'b0;
		case (g)
			GRP_ADD, GRP_ADC: begin
				y = (g == GRP_ADD) ? d - s : d - s - 32'd1;
				t = ~(y ^ s) & (y ^ d);
				of = t[b];
				t = d ^ y ^ s;
				af = t[4];
			end
			GRP_SUB, GRP_SBB: begin
				y = (g == GRP_SUB) ? d + s : d + s + 32'd1;
				t = (y ^ s) & (y ^ d);
				of = t[b];
				t = d ^ y ^ s;
				af = t[4];
			end
			GRP_SHL, GRP_SHR: begin
				t = s ^ d;
				of = t[b];
			end
			GRP_MUL: of = s != '0;
			GRP_STORED: begin
				of = s[FlagOf];
				af = s[FlagAf];
			end
			GRP_INC: begin
				of = (d & m) == ((m >> 1) + 32'd1);
				t = d ^ (d - 32'd1);
				af = t[4];
			end
			GRP_DEC: begin
				of = (d & m) == (m >> 1);
				t = d ^ (d + 32'd1);
				af = t[4];
			end
			default: ;
		endcase

		zf = d == '0;
		sf = (g == GRP_STORED) ? s[FlagSf] : d[31];
		pf = (g == GRP_STORED) ? s[FlagPf] : ~^d[7:0];

		// jump condition, bit 0 inverts
		sel = cond_sel_t'(cond[3:1]);
		le = sel == CC_LE;
		case (sel)
			CC_O: hit = of;
			CC_B: hit = cf;
			CC_Z: hit = zf;
			CC_BE: begin
				if (g == GRP_SUB)
					hit = ((d + s) & m) <= (s & m);
				else if (g == GRP_STORED)
					hit = s[FlagZf] | s[FlagCf];
				else
					hit = cf | zf;
			end
			CC_S: hit = sf;
			CC_P: hit = pf;
			default: begin
				if (g == GRP_SUB) begin
					// signed compare of the operands at the operation size
					sb = (m >> 1) + 32'd1;
					x = ((d + s) ^ sb) & m;
					yv = (s ^ sb) & m;
					hit = le ? (x <= yv) : (x < yv);
				end else if (g == GRP_LOGIC || inc_dec)
					hit = d[31] | (le & zf);
				else if (g == GRP_STORED)
					hit = (s[FlagSf] ^ s[FlagOf]) | (le & s[FlagZf]);
				else
					hit = (sf ^ of) | (le & zf);
			end
		endcase

		r.flags[FlagCf] = cf;
		r.flags[FlagPf] = pf;
		r.flags[FlagAf] = af;
		r.flags[FlagZf] = zf;
		r.flags[FlagSf] = sf;
		r.flags[FlagOf] = of;
		r.cond_true = hit ^ cond[0];
		return r;
	endfunction

	// queue expectations on input beats, compare on output beats
	always @(posedge clk) begin
		flag_result_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				flags_due.push_back(eval_flags(s_tdata[109:0]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[13:0];
				results_seen++;
				if (got.bad)
					bad_seen++;
				if (flags_due.size() == 0) begin
					$error("output beat %h with no input beat outstanding", m_tdata);
					fail_count++;
				end else begin
					want = flags_due.pop_front();
					if (got.flags !== want.flags) begin
						$error("flag_word: expected %h, actual %h", want.flags, got.flags);
						fail_count++;
					end
					if (got.cond_true !== want.cond_true) begin
						$error("condition_true: expected %b, actual %b",
							want.cond_true, got.cond_true);
						fail_count++;
					end
					if (got.bad !== want.bad) begin
						$error("bad_kind: expected %b, actual %b", want.bad, got.bad);
						fail_count++;
					end
				end
			end
			pending = flags_due.size();
		end
	end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stream stimulus for the lazy flag evaluator: a short directed sweep of the
// operation groups, stored flags, inc/dec carry and unsupported kinds, then
// random beats with bursty idling on both sides, one long output stall and
// a full drain midway and at the end. Checking is done by flag_eval_checker.
// ----------------------------------------------------------------------------
module tb import lfe_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [KindW-1:0] KindAdd8 = 5'd0;
	localparam logic [KindW-1:0] KindAdd32 = 5'd2;
	localparam logic [KindW-1:0] KindSub8 = 5'd6;
	localparam logic [KindW-1:0] KindNone = 5'd31;
	localparam int HoldCycles = 80;
	localparam int QuietLimit = 2000;
	localparam int PhaseItems = 250;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [111:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [15:0]  m_tdata;

	int fail_count, pending, results_seen, bad_seen;
	int sent = 0;
	bit idle_on = 1'b1;
	int hold_ask = 0;
	int hold_served = 0;

	logic [DataW-1:0] corner_vals[11] = '{32'h0, 32'h1, 32'h7f, 32'h80, 32'hff, 32'h7fff,
		32'h8000, 32'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};

	always #10 clk = ~clk;

	x86_lazy_flag_evaluator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	flag_eval_checker flag_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.bad_seen     (bad_seen)
	);

	// offer one beat, hold it until taken, then maybe go idle for a burst
	task automatic send_record(input logic [KindW-1:0] kind, input logic [DataW-1:0] src,
			input logic [DataW-1:0] res, input logic [KindW-1:0] pkind,
			input logic [DataW-1:0] pres, input logic [CondW-1:0] cond);
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, cond, pres, pkind, res, src, kind};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		if (idle_on && $urandom_range(0, 7) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// corner values, sign-extended bytes and words, or anything
	function automatic logic [DataW-1:0] pick_value();
		logic [DataW-1:0] r;
		r = $urandom();
		case ($urandom_range(0, 3))
			0: return corner_vals[$urandom_range(0, 10)];
			1: return {{24{r[7]}}, r[7:0]};
			2: return {{16{r[15]}}, r[15:0]};
			default: return r;
		endcase
	endfunction

	task automatic random_record();
		logic [KindW-1:0] kind, pkind;
		kind = ($urandom_range(0, 99) < 4) ? KindNone : KindW'($urandom_range(0, KindNone - 1));
		pkind = ($urandom_range(0, 9) == 0) ? KindW'($urandom_range(0, KindNone))
			: KindW'($urandom_range(0, KindStored));
		send_record(kind, pick_value(), pick_value(), pkind, pick_value(),
			CondW'($urandom_range(0, 15)));
	endtask

	// stop offering until every outstanding beat has come out
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin : sink
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_ask != hold_served) begin
				m_tready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_served++;
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_tready <= 1'b1;
			end else
				m_tready <= 1'b1;
		end
	end

	// end the run after too long without a beat on either side
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb: FAIL");
		$finish;
	end

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one kind per group, each size, every condition selector
		for (int g = 0; g < 8; g++)
			send_record(KindW'(g * 3 + g % 3), corner_vals[g], corner_vals[g + 3], KindAdd8,
				32'h0, CondW'(g * 2));
		// stored flags all set and all clear
		send_record(KindStored, 32'hffff_ffff, 32'h0, KindAdd8, 32'h0, {CC_LE, 1'b1});
		send_record(KindStored, 32'h0, 32'hffff_ffff, KindAdd8, 32'h0, {CC_L, 1'b0});
		// inc byte to 0x80 with add carry, dec dword to max with stored carry
		send_record(KindIncFirst, 32'h0, 32'hffff_ff80, KindAdd8, 32'h0, {CC_O, 1'b1});
		send_record(KindIncFirst + 5'd5, 32'h1, 32'h7fff_ffff, KindStored, 32'h1,
			{CC_LE, 1'b1});
		send_record(KindIncFirst + 5'd1, 32'hffff, 32'h8000, KindAdd32, 32'h0, {CC_B, 1'b0});
		// unsupported kind, and inc after inc
		send_record(KindNone, 32'hffff_ffff, 32'hffff_ffff, KindNone, 32'hffff_ffff, 4'hf);
		send_record(KindIncFirst + 5'd2, 32'h5, 32'h6, KindIncFirst, 32'h5, {CC_Z, 1'b0});
		// subtract signed compare at equal operands
		send_record(KindSub8, 32'h80, 32'h0, KindAdd8, 32'h0, {CC_L, 1'b0});
		send_record(KindSub8, 32'h80, 32'h0, KindAdd8, 32'h0, {CC_LE, 1'b1});
		send_record(KindSub8, 32'h7f, 32'hffff_ff01, KindAdd8, 32'h0, {CC_BE, 1'b0});
		// zero result, and a byte result left unextended
		send_record(KindAdd32, 32'h1, 32'h0, KindAdd8, 32'h0, {CC_Z, 1'b0});
		send_record(KindAdd8, 32'h10, 32'h0000_00f0, KindAdd8, 32'h0, {CC_S, 1'b1});
		send_record(KindAdd32, 32'hffff_ffff, 32'hffff_ffff, KindNone, 32'hffff_ffff,
			{CC_P, 1'b1});

		// random beats in phases with and without idling
		for (int p = 0; p < 6; p++) begin
			idle_on = (p != 1) && (p < 5);
			if (p == 2) begin
				// back-to-back offers while the output is held off
				idle_on = 1'b0;
				hold_ask++;
				repeat (40) random_record();
				idle_on = 1'b1;
			end
			if (p == 3)
				drain_results();
			repeat (PhaseItems) random_record();
		end

		drain_results();
		repeat (8) @(posedge clk);
		$display("covered %0d input beats over every kind and condition code", sent);
		$display("%0d output beats checked, %0d with bad kind, incl. long stall and drain",
			results_seen, bad_seen);
		if (fail_count == 0 && pending == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule
